[src/iaie_pkg.sv]
// shared types and constants for the indexed array insert/erase block
// no dependencies; used by the channel interfaces, the cell and the top level
package iaie_pkg;

  // fixed field widths of the channels
  localparam int KIND_W = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    REQ_GET    = 3'd0,
    REQ_SET    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_PUSH   = 3'd4,
    REQ_POP    = 3'd5,
    REQ_CLEAR  = 3'd6,
    REQ_RESIZE = 3'd7
  } req_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_BIG   = 2'd3
  } status_t;

  // command broadcast to every cell
  typedef struct packed {
    logic go;
    req_t kind;
  } cell_cmd_t;

endpackage

[src/iaie_chan_if.sv]
// request and result channel interfaces (valid/ready with payload)
// depends on iaie_pkg for the field widths
interface iaie_in_if;
  logic                           valid;
  logic                           ready;
  logic [iaie_pkg::KIND_W-1:0]    req_type;
  logic [iaie_pkg::POS_W-1:0]     position;
  logic [iaie_pkg::VAL_W-1:0]     entry_value;

  modport source (output valid, req_type, position, entry_value, input ready);
  modport sink   (input valid, req_type, position, entry_value, output ready);
endinterface

interface iaie_out_if;
  logic                           valid;
  logic                           ready;
  logic [iaie_pkg::VAL_W-1:0]     read_value;
  logic [iaie_pkg::ST_W-1:0]      status;
  logic [iaie_pkg::POS_W-1:0]     length_now;

  modport source (output valid, read_value, status, length_now, input ready);
  modport sink   (input valid, read_value, status, length_now, output ready);
endinterface

[src/iaie_cell.sv]
// one storage cell of the array: holds the entry at a fixed index
// depends on iaie_pkg for the broadcast command type
module iaie_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int EW  = 32
) (
  input  logic                clk,
  input  iaie_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]       pos,
  input  logic [CW-1:0]       len,
  input  logic [EW-1:0]       wr_val,
  input  logic [EW-1:0]       left_data,
  input  logic [EW-1:0]       right_data,
  output logic [EW-1:0]       data
);

  localparam logic [CW:0] ME    = (CW+1)'(IDX);
  localparam logic [CW:0] ME_P1 = (CW+1)'(IDX + 1);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;
  logic [CW:0]   pos_x;
  logic [CW:0]   len_x;

  assign pos_x = {1'b0, pos};
  assign len_x = {1'b0, len};

  // per-cell update from own index compare against position and length
  always_comb begin
    data_nxt = data_r;
    if (cmd.go) begin
      case (cmd.kind)
        iaie_pkg::REQ_SET: begin
          if (ME == pos_x) data_nxt = wr_val;
        end
        iaie_pkg::REQ_INSERT: begin
          if (ME == pos_x) data_nxt = wr_val;
          else if (ME > pos_x && ME <= len_x) data_nxt = left_data;
        end
        iaie_pkg::REQ_ERASE: begin
          if (ME >= pos_x && ME_P1 < len_x) data_nxt = right_data;
        end
        iaie_pkg::REQ_PUSH: begin
          if (ME == len_x) data_nxt = wr_val;
        end
        iaie_pkg::REQ_RESIZE: begin
          if (ME >= len_x && ME < pos_x) data_nxt = wr_val;
        end
        default: begin
          data_nxt = data_r;
        end
      endcase
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[src/indexed_array_insert_erase_top.sv]
// top level of the indexed array insert/erase block: row of cells, request
// decode, read select and a two-deep result buffer; uses iaie_pkg, iaie_cell
// and the channel interfaces
//
//   channel  dir   fields                                  transfer when
//   in_ch    in    req_type, position, entry_value         valid && ready
//   out_ch   out   read_value, status, length_now          valid && ready
//
// one request per cycle while in_ch.ready is high: every cell shifts, loads or fills
// on its own index compare in the cycle of the transfer, and the result is registered.
// a result buffer of two entries lets one more request in while a result
// waits; in_ch.ready drops only when both entries hold results.
// rst_n (synchronous, active low) empties the array and the result buffer;
// the entries themselves are not cleared.
module indexed_array_insert_erase_top #(
  parameter int CAPACITY   = 16,
  parameter int ENTRY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  iaie_in_if.sink     in_ch,
  iaie_out_if.source  out_ch
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CW    = (LEN_W > iaie_pkg::POS_W) ? LEN_W : iaie_pkg::POS_W;
  localparam int IW    = $clog2(CAPACITY);
  localparam int WW    = (ENTRY_BITS > iaie_pkg::VAL_W) ? ENTRY_BITS : iaie_pkg::VAL_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef struct packed {
    logic [iaie_pkg::VAL_W-1:0] rd;
    iaie_pkg::status_t          st;
    logic [iaie_pkg::POS_W-1:0] len;
  } result_t;

  logic [CW-1:0]         len_r;
  logic [CW-1:0]         len_nxt;
  logic                  out_vld_r;
  result_t               out_r;
  logic                  skid_vld_r;
  result_t               skid_r;

  logic                  acc;
  iaie_pkg::req_t        kind;
  logic [CW-1:0]         pos_c;
  logic [WW-1:0]         in_wide;
  logic [ENTRY_BITS-1:0] wr_val;
  iaie_pkg::status_t     st;
  logic                  is_read;
  logic [CW-1:0]         rd_addr_c;
  logic [IW-1:0]         rd_addr;
  logic [WW-1:0]         rd_wide;
  result_t               res;
  iaie_pkg::cell_cmd_t   cmd;
  logic [ENTRY_BITS-1:0] cell_data [CAPACITY];

  // input decode
  assign in_ch.ready = !skid_vld_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign kind        = iaie_pkg::req_t'(in_ch.req_type);
  assign pos_c       = CW'(in_ch.position);
  assign in_wide     = WW'(in_ch.entry_value);
  assign wr_val      = in_wide[ENTRY_BITS-1:0];

  // range, fullness and capacity checks
  always_comb begin
    st      = iaie_pkg::ST_OK;
    is_read = 1'b0;
    len_nxt = len_r;
    case (kind)
      iaie_pkg::REQ_GET: begin
        if (pos_c >= len_r) st = iaie_pkg::ST_RANGE;
        else is_read = 1'b1;
      end
      iaie_pkg::REQ_SET: begin
        if (pos_c >= len_r) st = iaie_pkg::ST_RANGE;
      end
      iaie_pkg::REQ_INSERT: begin
        if (pos_c > len_r) st = iaie_pkg::ST_RANGE;
        else if (len_r >= CAP_C) st = iaie_pkg::ST_FULL;
        else len_nxt = len_r + CW'(1);
      end
      iaie_pkg::REQ_ERASE: begin
        if (pos_c >= len_r) st = iaie_pkg::ST_RANGE;
        else begin
          is_read = 1'b1;
          len_nxt = len_r - CW'(1);
        end
      end
      iaie_pkg::REQ_PUSH: begin
        if (len_r >= CAP_C) st = iaie_pkg::ST_FULL;
        else len_nxt = len_r + CW'(1);
      end
      iaie_pkg::REQ_POP: begin
        if (len_r == '0) st = iaie_pkg::ST_RANGE;
        else begin
          is_read = 1'b1;
          len_nxt = len_r - CW'(1);
        end
      end
      iaie_pkg::REQ_CLEAR: begin
        len_nxt = '0;
      end
      iaie_pkg::REQ_RESIZE: begin
        if (pos_c > CAP_C) st = iaie_pkg::ST_BIG;
        else len_nxt = pos_c;
      end
      default: begin
        st = iaie_pkg::ST_OK;
      end
    endcase
  end

  // command broadcast to the cell row
  assign cmd.go   = acc && (st == iaie_pkg::ST_OK);
  assign cmd.kind = kind;

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] left_d;
    logic [ENTRY_BITS-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = wr_val;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    iaie_cell #(
      .IDX (i),
      .CW  (CW),
      .EW  (ENTRY_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_c),
      .len        (len_r),
      .wr_val     (wr_val),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  // read select: last entry for pop, position otherwise
  assign rd_addr_c = (kind == iaie_pkg::REQ_POP) ? (len_r - CW'(1)) : pos_c;
  assign rd_addr   = rd_addr_c[IW-1:0];
  assign rd_wide   = WW'(cell_data[rd_addr]);

  // result assembly
  assign res.rd  = is_read ? rd_wide[iaie_pkg::VAL_W-1:0] : '0;
  assign res.st  = st;
  assign res.len = len_nxt[iaie_pkg::POS_W-1:0];

  // length register and two-deep result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (acc) len_r <= len_nxt;
      if (!out_vld_r || out_ch.ready) begin
        if (skid_vld_r) begin
          out_r      <= skid_r;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= acc;
          out_r     <= res;
        end
      end else if (acc) begin
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.read_value = out_r.rd;
  assign out_ch.status     = out_r.st;
  assign out_ch.length_now = out_r.len;

  // buffer order: the second entry is used only behind the first
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("result buffer second entry valid without first");

  // live length stays within capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_C)
    else $error("live length above capacity");

  // a refused request leaves the length alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st != iaie_pkg::ST_OK) |=> $stable(len_r))
    else $error("refused request changed the length");

  // clear empties the array
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && kind == iaie_pkg::REQ_CLEAR) |=> (len_r == '0))
    else $error("clear left entries live");

endmodule

[tb/sv/tb_indexed_array_insert_erase_top.sv]
`timescale 1ns / 1ps
// testbench for indexed_array_insert_erase_top: directed and random requests,
// every result checked against a shadow copy of the array
// depends on iaie_pkg, the iaie channel interfaces and the top-level rtl
module tb_indexed_array_insert_erase_top;

  localparam int CAPACITY     = 16;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 4;
  localparam int POS_W        = iaie_pkg::POS_W;
  localparam int VAL_W        = iaie_pkg::VAL_W;

  typedef struct {
    logic [VAL_W-1:0]  read_value;
    iaie_pkg::status_t status;
    logic [POS_W-1:0]  length_now;
  } array_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  iaie_in_if  in_ch();
  iaie_out_if out_ch();

  indexed_array_insert_erase_top #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (VAL_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the array and the results still owed by the block
  logic [VAL_W-1:0] shadow_entries [CAPACITY];
  int               shadow_len = 0;
  array_result_t    pending_results [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int peak_len        = 0;
  int kind_count [8]   = '{default: 0};
  int status_count [4] = '{default: 0};

  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  int stall_left = 0;

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // applies one request to the shadow array and returns the result it owes
  function automatic array_result_t apply_array_request(iaie_pkg::req_t kind,
                                                        logic [POS_W-1:0] pos,
                                                        logic [VAL_W-1:0] val);
    array_result_t res;
    int            idx;
    int            p;
    p              = int'(pos);
    res.read_value = '0;
    res.status     = iaie_pkg::ST_OK;
    case (kind)
      iaie_pkg::REQ_GET: begin
        if (p >= shadow_len) res.status = iaie_pkg::ST_RANGE;
        else res.read_value = shadow_entries[p];
      end
      iaie_pkg::REQ_SET: begin
        if (p >= shadow_len) res.status = iaie_pkg::ST_RANGE;
        else shadow_entries[p] = val;
      end
      iaie_pkg::REQ_INSERT: begin
        // index error wins over fullness
        if (p > shadow_len) res.status = iaie_pkg::ST_RANGE;
        else if (shadow_len >= CAPACITY) res.status = iaie_pkg::ST_FULL;
        else begin
          for (idx = shadow_len; idx > p; idx--) shadow_entries[idx] = shadow_entries[idx-1];
          shadow_entries[p] = val;
          shadow_len++;
        end
      end
      iaie_pkg::REQ_ERASE: begin
        if (p >= shadow_len) res.status = iaie_pkg::ST_RANGE;
        else begin
          res.read_value = shadow_entries[p];
          for (idx = p; idx + 1 < shadow_len; idx++) shadow_entries[idx] = shadow_entries[idx+1];
          shadow_len--;
        end
      end
      iaie_pkg::REQ_PUSH: begin
        if (shadow_len >= CAPACITY) res.status = iaie_pkg::ST_FULL;
        else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end
      end
      iaie_pkg::REQ_POP: begin
        if (shadow_len == 0) res.status = iaie_pkg::ST_RANGE;
        else begin
          shadow_len--;
          res.read_value = shadow_entries[shadow_len];
        end
      end
      iaie_pkg::REQ_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        // resize: grow fills new slots, shrink just drops the tail
        if (p > CAPACITY) res.status = iaie_pkg::ST_BIG;
        else begin
          for (idx = shadow_len; idx < p; idx++) shadow_entries[idx] = val;
          shadow_len = p;
        end
      end
    endcase
    res.length_now = POS_W'(shadow_len);
    kind_count[kind]++;
    status_count[res.status]++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    return res;
  endfunction

  // result check first, then prediction of the request taken at the same edge
  always @(posedge clk) begin
    array_result_t owed;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing owed: read_value %h status %0d length_now %0d",
                 out_ch.read_value, out_ch.status, out_ch.length_now);
          mismatch_count++;
        end else begin
          owed = pending_results.pop_front();
          results_checked++;
          if (out_ch.read_value !== owed.read_value) begin
            $error("read_value: expected %h, got %h", owed.read_value, out_ch.read_value);
            mismatch_count++;
          end
          if (out_ch.status !== owed.status) begin
            $error("status: expected %s, got %0d", owed.status.name(), out_ch.status);
            mismatch_count++;
          end
          if (out_ch.length_now !== owed.length_now) begin
            $error("length_now: expected %0d, got %0d", owed.length_now, out_ch.length_now);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready === 1'b1)
        pending_results.push_back(apply_array_request(iaie_pkg::req_t'(in_ch.req_type),
                                                      in_ch.position, in_ch.entry_value));
    end
  end

  // idle length: mostly short, now and then long
  function automatic int pick_idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(6, 24);
    return $urandom_range(1, 3);
  endfunction

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left   = pick_idle_len() - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // one request transfer; starts and ends at a falling edge
  task automatic send_request(input iaie_pkg::req_t kind, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 40) gap = pick_idle_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type    = kind;
    in_ch.position    = pos;
    in_ch.entry_value = val;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // requests that meet an empty array
  task automatic test_empty_array();
    send_request(iaie_pkg::REQ_GET,    5'd0,  32'h1111_1111);
    send_request(iaie_pkg::REQ_POP,    5'd0,  32'h0);
    send_request(iaie_pkg::REQ_ERASE,  5'd0,  32'h0);
    send_request(iaie_pkg::REQ_SET,    5'd0,  32'h2222_2222);
    send_request(iaie_pkg::REQ_INSERT, 5'd1,  32'h3333_3333);
  endtask

  // inserts at the front, middle and end; erases in the middle and at the end
  task automatic test_shift_ops();
    send_request(iaie_pkg::REQ_PUSH,   5'd0,  32'hFFFF_FFFF);
    send_request(iaie_pkg::REQ_PUSH,   5'd31, 32'h0000_0000);
    send_request(iaie_pkg::REQ_INSERT, 5'd0,  32'hA5A5_A5A5);
    send_request(iaie_pkg::REQ_INSERT, 5'd3,  32'h5A5A_5A5A);
    send_request(iaie_pkg::REQ_INSERT, 5'd1,  32'h1234_5678);
    send_request(iaie_pkg::REQ_GET,    5'd4,  32'h0);
    send_request(iaie_pkg::REQ_SET,    5'd2,  32'hDEAD_BEEF);
    send_request(iaie_pkg::REQ_GET,    5'd2,  32'h0);
    send_request(iaie_pkg::REQ_ERASE,  5'd1,  32'h0);
    send_request(iaie_pkg::REQ_ERASE,  5'd3,  32'h0);
    send_request(iaie_pkg::REQ_GET,    5'd3,  32'h0);
    send_request(iaie_pkg::REQ_POP,    5'd0,  32'h0);
  endtask

  // full array, oversized and shrinking resize, clear
  task automatic test_capacity_and_resize();
    send_request(iaie_pkg::REQ_RESIZE, 5'd16, 32'hC3C3_C3C3);
    send_request(iaie_pkg::REQ_PUSH,   5'd0,  32'h7777_7777);
    send_request(iaie_pkg::REQ_INSERT, 5'd5,  32'h8888_8888);
    send_request(iaie_pkg::REQ_INSERT, 5'd17, 32'h9999_9999);
    send_request(iaie_pkg::REQ_RESIZE, 5'd17, 32'h0);
    send_request(iaie_pkg::REQ_RESIZE, 5'd31, 32'h0);
    send_request(iaie_pkg::REQ_RESIZE, 5'd4,  32'hFFFF_FFFF);
    send_request(iaie_pkg::REQ_GET,    5'd3,  32'h0);
    send_request(iaie_pkg::REQ_CLEAR,  5'd9,  32'h0);
    send_request(iaie_pkg::REQ_ERASE,  5'd0,  32'h0);
    send_request(iaie_pkg::REQ_RESIZE, 5'd0,  32'h0);
  endtask

  // request kind, leaning toward growth, shrinkage or neither
  function automatic iaie_pkg::req_t pick_kind(int lean);
    int r;
    r = $urandom_range(0, 99);
    case (lean)
      0: begin
        if (r < 30) return iaie_pkg::REQ_PUSH;
        if (r < 55) return iaie_pkg::REQ_INSERT;
        if (r < 67) return iaie_pkg::REQ_GET;
        if (r < 79) return iaie_pkg::REQ_SET;
        if (r < 87) return iaie_pkg::REQ_ERASE;
        if (r < 95) return iaie_pkg::REQ_POP;
        if (r < 99) return iaie_pkg::REQ_RESIZE;
        return iaie_pkg::REQ_CLEAR;
      end
      1: begin
        if (r < 8)  return iaie_pkg::REQ_PUSH;
        if (r < 16) return iaie_pkg::REQ_INSERT;
        if (r < 28) return iaie_pkg::REQ_GET;
        if (r < 40) return iaie_pkg::REQ_SET;
        if (r < 68) return iaie_pkg::REQ_ERASE;
        if (r < 94) return iaie_pkg::REQ_POP;
        if (r < 99) return iaie_pkg::REQ_RESIZE;
        return iaie_pkg::REQ_CLEAR;
      end
      default: begin
        if (r < 15) return iaie_pkg::REQ_PUSH;
        if (r < 30) return iaie_pkg::REQ_INSERT;
        if (r < 45) return iaie_pkg::REQ_GET;
        if (r < 60) return iaie_pkg::REQ_SET;
        if (r < 75) return iaie_pkg::REQ_ERASE;
        if (r < 90) return iaie_pkg::REQ_POP;
        if (r < 98) return iaie_pkg::REQ_RESIZE;
        return iaie_pkg::REQ_CLEAR;
      end
    endcase
  endfunction

  // index mostly legal, some just past the end, a few anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(iaie_pkg::req_t kind);
    int top;
    int r;
    case (kind)
      iaie_pkg::REQ_INSERT: top = shadow_len;
      iaie_pkg::REQ_RESIZE: top = CAPACITY;
      default:              top = (shadow_len > 0) ? shadow_len - 1 : 0;
    endcase
    r = $urandom_range(0, 99);
    if (r < 80) return POS_W'($urandom_range(0, top));
    if (r < 95) return POS_W'(top + 1);
    return POS_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // random traffic in stretches of changing lean, some with no idling at all
  task automatic test_random_traffic(input int n_items);
    iaie_pkg::req_t kind;
    int             i;
    for (i = 0; i < n_items; i++) begin
      gaps_on   = ((i / 100) % 3) != 2;
      stalls_on = gaps_on;
      kind      = pick_kind((i / 80) % 3);
      send_request(kind, pick_position(kind), pick_value());
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // sequence of tests
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.req_type    = iaie_pkg::REQ_GET;
    in_ch.position    = '0;
    in_ch.entry_value = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_empty_array();
    test_shift_ops();
    test_capacity_and_resize();
    test_random_traffic(RANDOM_ITEMS);
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results; requests get %0d set %0d insert %0d erase %0d push %0d",
             results_checked, kind_count[iaie_pkg::REQ_GET], kind_count[iaie_pkg::REQ_SET],
             kind_count[iaie_pkg::REQ_INSERT], kind_count[iaie_pkg::REQ_ERASE],
             kind_count[iaie_pkg::REQ_PUSH]);
    $display("pop %0d clear %0d resize %0d; status ok %0d range %0d full %0d big %0d; peak %0d",
             kind_count[iaie_pkg::REQ_POP], kind_count[iaie_pkg::REQ_CLEAR],
             kind_count[iaie_pkg::REQ_RESIZE], status_count[iaie_pkg::ST_OK],
             status_count[iaie_pkg::ST_RANGE], status_count[iaie_pkg::ST_FULL],
             status_count[iaie_pkg::ST_BIG], peak_len);
    if (mismatch_count == 0) begin
      $display("PASS indexed_array_insert_erase_top");
    end else begin
      $display("FAIL indexed_array_insert_erase_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL indexed_array_insert_erase_top");
    $finish;
  end

endmodule

[indexed_array_insert_erase_top.f]
src/iaie_pkg.sv
src/iaie_chan_if.sv
src/iaie_cell.sv
src/indexed_array_insert_erase_top.sv
tb/sv/tb_indexed_array_insert_erase_top.sv
